@@ hw/rtl/binary_min_heap_queue_core_assert.svh @@
// Assertion macros for the binary min-heap queue core.
// Included by the RTL files that check their own logic; needs i_clk and i_rst_n in scope.
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTH

// clocked check, idle while reset is held
`define BMHQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define BMHQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define BMHQ_ASSERT(label, prop, msg)

`define BMHQ_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ hw/rtl/bmhq_pkg.sv @@
// Shared types and constants of the binary min-heap queue core.
// No dependencies; imported by bmhq_ram and binary_min_heap_queue_core.
package bmhq_pkg;

    localparam int DefDepth  = 64;
    localparam int KeyW      = 32;
    localparam int LimitW    = 7;
    localparam int EntryW    = 7;
    localparam int OpW       = 2;
    localparam int StatusW   = 2;
    localparam int CfgAddrW  = 3;
    localparam int CfgDataW  = 32;

    localparam logic [LimitW-1:0] LimitReset = 7'd64;

    // operation codes
    localparam logic [OpW-1:0] OpInsert  = 2'd0;
    localparam logic [OpW-1:0] OpExtract = 2'd1;
    localparam logic [OpW-1:0] OpPeek    = 2'd2;

    // status codes
    localparam logic [StatusW-1:0] StOk    = 2'd0;
    localparam logic [StatusW-1:0] StEmpty = 2'd1;
    localparam logic [StatusW-1:0] StFull  = 2'd2;

    // register word index
    localparam logic [0:0] RegCapacity = 1'b0;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_UP   = 6'b000010,
        S_EX   = 6'b000100,
        S_DN   = 6'b001000,
        S_WRF  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

endpackage

@@ hw/rtl/bmhq_ram.sv @@
// Generic RAM: one write port and two read ports, read data registered.
// Depends on bmhq_pkg only for the default width and depth.
module bmhq_ram
    import bmhq_pkg::*;
#(
    parameter int Width = KeyW,
    parameter int Depth = DefDepth
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr_a,
    input  logic [$clog2(Depth)-1:0] i_raddr_b,
    output logic [Width-1:0]         o_rdata_a,
    output logic [Width-1:0]         o_rdata_b
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata_a;
    logic [Width-1:0] r_rdata_b;

    // write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ hw/rtl/binary_min_heap_queue_core.sv @@
// Binary min-heap priority queue. Insert: written to the root of an empty heap, else
// sifted up level by level (read parent, compare, write). Extract: root and last
// entry read, then sifted down level by level with both children read on the two
// RAM ports. Peek and errors finish without a sift.
// One word in flight at a time; the result register lets the next word enter.
// Synchronous active-low reset clears the count, control and capacity (64).
module binary_min_heap_queue_core
    import bmhq_pkg::*;
#(
    parameter int DEPTH = DefDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input word
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [KeyW-1:0]     s_axis_tdata,  // [31:0] key_in
    input  logic [OpW-1:0]      s_axis_tuser,  // [1:0] operation
    // result word
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,  // [31:0] key_out, [38:32] entry_count, [39] 0
    output logic [StatusW-1:0]  m_axis_tuser,  // [1:0] status
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CapW = (CW > LimitW) ? CW : LimitW;
    localparam int LW   = AW + 2;

    t_state                r_state, n_state;
    logic [OpW-1:0]        r_op, n_op;
    logic signed [KeyW-1:0] r_key, n_key;
    logic [AW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_count, n_count;
    logic signed [KeyW-1:0] r_res_key, n_res_key;
    logic [StatusW-1:0]    r_res_status, n_res_status;
    logic [LimitW-1:0]     r_limit;
    logic                  r_out_valid;
    logic signed [KeyW-1:0] r_out_key;
    logic [StatusW-1:0]    r_out_status;
    logic [CW-1:0]         r_out_count;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic signed [KeyW-1:0] mem_wdata;
    logic [AW-1:0]         rd_addr_a, rd_addr_b;
    logic signed [KeyW-1:0] rd_data_a, rd_data_b;

    logic [CapW-1:0]       cap;
    logic                  heap_full;
    logic [AW-1:0]         cnt_aw;
    logic [AW-1:0]         up_parent;
    logic [AW-1:0]         ins_parent;
    logic [LW-1:0]         dn_left, dn_right, dn_next_left, cnt_lw;
    logic                  dn_right_ok;
    logic                  dn_take_right;
    logic signed [KeyW-1:0] dn_child;
    logic [AW-1:0]         dn_pick;
    logic                  out_load;
    logic                  cfg_write;
    logic [CW+EntryW-1:0]  out_count_wide;

    bmhq_ram #(
        .Width (KeyW),
        .Depth (DEPTH)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (rd_data_a),
        .o_rdata_b (rd_data_b)
    );

    // effective capacity saturates at DEPTH
    always_comb begin
        if (CapW'(r_limit) < CapW'(DEPTH)) begin
            cap = CapW'(r_limit);
        end else begin
            cap = CapW'(DEPTH);
        end
    end
    assign heap_full = CapW'(r_count) >= cap;

    // index arithmetic
    assign cnt_aw        = r_count[AW-1:0];
    assign ins_parent    = (cnt_aw - AW'(1)) >> 1;
    assign up_parent     = (r_pos - AW'(1)) >> 1;
    assign cnt_lw        = LW'(r_count);
    assign dn_left       = {1'b0, r_pos, 1'b1};
    assign dn_right      = dn_left + LW'(1);
    assign dn_right_ok   = dn_right < cnt_lw;
    assign dn_take_right = dn_right_ok && (rd_data_b < rd_data_a);
    assign dn_child      = dn_take_right ? rd_data_b : rd_data_a;
    assign dn_pick       = dn_take_right ? dn_right[AW-1:0] : dn_left[AW-1:0];
    assign dn_next_left  = {1'b0, dn_pick, 1'b1};

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_load      = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    // sequencer: read, compare, write back one heap level per cycle
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_pos        = r_pos;
        n_count      = r_count;
        n_res_key    = r_res_key;
        n_res_status = r_res_status;
        mem_we       = 1'b0;
        mem_waddr    = r_pos;
        mem_wdata    = r_key;
        rd_addr_a    = '0;
        rd_addr_b    = '0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op         = s_axis_tuser;
                    n_key        = s_axis_tdata;
                    n_res_key    = '0;
                    n_res_status = StOk;
                    n_state      = S_FIN;
                    case (s_axis_tuser)
                        OpInsert: begin
                            if (heap_full) begin
                                n_res_status = StFull;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_pos   = cnt_aw;
                                if (r_count == '0) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = '0;
                                    mem_wdata = s_axis_tdata;
                                end else begin
                                    rd_addr_a = ins_parent;
                                    n_state   = S_UP;
                                end
                            end
                        end
                        OpExtract, OpPeek: begin
                            if (r_count == '0) begin
                                n_res_status = StEmpty;
                            end else begin
                                rd_addr_a = '0;
                                rd_addr_b = cnt_aw - AW'(1);
                                n_state   = S_EX;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_UP: begin
                if (r_key < rd_data_a) begin
                    // parent moves down into the hole
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = rd_data_a;
                    n_pos     = up_parent;
                    if (up_parent == '0) begin
                        n_state = S_WRF;
                    end else begin
                        rd_addr_a = (up_parent - AW'(1)) >> 1;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_key;
                    n_state   = S_FIN;
                end
            end
            S_EX: begin
                n_res_key = rd_data_a;
                n_state   = S_FIN;
                if (r_op == OpExtract) begin
                    n_key   = rd_data_b;
                    n_count = r_count - CW'(1);
                    n_pos   = '0;
                    if (r_count == CW'(2)) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = rd_data_b;
                    end else if (r_count > CW'(2)) begin
                        rd_addr_a = AW'(1);
                        rd_addr_b = AW'(2);
                        n_state   = S_DN;
                    end
                end
            end
            S_DN: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                if (r_key < dn_child) begin
                    mem_wdata = r_key;
                    n_state   = S_FIN;
                end else begin
                    // smaller child moves up into the hole
                    mem_wdata = dn_child;
                    n_pos     = dn_pick;
                    if (dn_next_left >= cnt_lw) begin
                        n_state = S_WRF;
                    end else begin
                        rd_addr_a = dn_next_left[AW-1:0];
                        rd_addr_b = dn_next_left[AW-1:0] + AW'(1);
                    end
                end
            end
            S_WRF: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_key;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_pos        <= n_pos;
        r_res_key    <= n_res_key;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_key    <= r_res_key;
            r_out_status <= r_res_status;
            r_out_count  <= r_count;
        end
    end

    // result word
    assign out_count_wide = {{EntryW{1'b0}}, r_out_count};
    assign m_axis_tvalid  = r_out_valid;
    assign m_axis_tdata   = {1'b0, out_count_wide[EntryW-1:0], r_out_key};
    assign m_axis_tuser   = r_out_status;

    // configuration register
    assign cfg_write = psel && penable && pwrite && pready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (cfg_write && (paddr[2] == RegCapacity)) begin
            r_limit <= pwdata[LimitW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegCapacity) ? CfgDataW'(r_limit) : '0;

`include "binary_min_heap_queue_core_assert.svh"

    `BMHQ_ASSERT(a_count_bound, CW'(r_count) <= CW'(DEPTH), "entry count above DEPTH")
    `BMHQ_ASSERT(a_accept_busy,
                 (s_axis_tvalid && s_axis_tready) |=> (r_state != S_IDLE),
                 "idle after accept")
    `BMHQ_ASSERT(a_empty_count,
                 (m_axis_tvalid && (m_axis_tuser == StEmpty)) |-> (r_out_count == '0),
                 "empty status with entries")
    `BMHQ_ASSERT(a_fin_count,
                 (r_state == S_FIN) |=> (r_count == $past(r_count)),
                 "count moved while finishing")

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for binary_min_heap_queue_core: stream words in, results checked
// against a mirror of the heap kept in the bench. Needs bmhq_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
    import bmhq_pkg::*;

    localparam int DEPTH = DefDepth;
    localparam logic [OpW-1:0] OpUnused = 2'd3;
    localparam logic [CfgAddrW-1:0] CapAddr = CfgAddrW'({RegCapacity, 2'b00});

    typedef struct packed {
        logic [KeyW-1:0]    key;
        logic [StatusW-1:0] status;
        logic [EntryW-1:0]  count;
    } t_heap_result;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [LimitW-1:0] cap;
        logic [OpW-1:0]   op;
        logic [KeyW-1:0]  key;
        logic             exact;
        t_heap_result     res;
    } t_dir_row;

    localparam int DIR_ROWS = 27;

    // directed rows; typed results only where they are obvious
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{ROW_WORD, 7'd0,   OpPeek,    32'h0000_0000, 1'b1, '{32'h0, StEmpty, 7'd0}},
        '{ROW_WORD, 7'd0,   OpExtract, 32'hDEAD_BEEF, 1'b1, '{32'h0, StEmpty, 7'd0}},
        '{ROW_WORD, 7'd0,   OpUnused,  32'hFFFF_FFFF, 1'b1, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpInsert,  32'h7FFF_FFFF, 1'b1, '{32'h0, StOk, 7'd1}},
        '{ROW_WORD, 7'd0,   OpInsert,  32'h8000_0000, 1'b1, '{32'h0, StOk, 7'd2}},
        '{ROW_WORD, 7'd0,   OpPeek,    32'h0000_0000, 1'b1, '{32'h8000_0000, StOk, 7'd2}},
        '{ROW_WORD, 7'd0,   OpInsert,  32'h0000_0000, 1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpInsert,  32'hFFFF_FFFF, 1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpInsert,  32'hFFFF_FFFF, 1'b0, '{32'h0, StOk, 7'd0}},
        // capacity dropped below the fill level
        '{ROW_CFG,  7'd2,   OpInsert,  32'h0,         1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpInsert,  32'h0000_0005, 1'b1, '{32'h0, StFull, 7'd5}},
        '{ROW_WORD, 7'd0,   OpExtract, 32'h0000_0000, 1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpExtract, 32'h0000_0000, 1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpExtract, 32'h0000_0000, 1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpInsert,  32'h0000_0007, 1'b1, '{32'h0, StFull, 7'd2}},
        '{ROW_WORD, 7'd0,   OpExtract, 32'h0000_0000, 1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpInsert,  32'h0000_0007, 1'b0, '{32'h0, StOk, 7'd0}},
        // zero capacity refuses every insert
        '{ROW_CFG,  7'd0,   OpInsert,  32'h0,         1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpInsert,  32'h0000_0001, 1'b1, '{32'h0, StFull, 7'd2}},
        '{ROW_WORD, 7'd0,   OpUnused,  32'h55AA_55AA, 1'b1, '{32'h0, StOk, 7'd2}},
        // limit above depth saturates
        '{ROW_CFG,  7'd127, OpInsert,  32'h0,         1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpInsert,  32'h1234_5678, 1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpExtract, 32'h0000_0000, 1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpExtract, 32'h0000_0000, 1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpExtract, 32'h0000_0000, 1'b0, '{32'h0, StOk, 7'd0}},
        '{ROW_WORD, 7'd0,   OpExtract, 32'hAAAA_5555, 1'b1, '{32'h0, StEmpty, 7'd0}},
        '{ROW_WORD, 7'd0,   OpPeek,    32'h0000_0000, 1'b1, '{32'h0, StEmpty, 7'd0}}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [KeyW-1:0]     s_axis_tdata = '0;    // [31:0] key_in
    logic [OpW-1:0]      s_axis_tuser = '0;    // [1:0] operation
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [39:0]         m_axis_tdata;         // [31:0] key_out, [38:32] entry_count, [39] 0
    logic [StatusW-1:0]  m_axis_tuser;         // [1:0] status
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CfgAddrW-1:0] paddr = '0;
    logic [CfgDataW-1:0] pwdata = '0;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    // mirror of the heap
    logic signed [KeyW-1:0] mirror_keys [DEPTH];
    int                     mirror_count = 0;
    int                     mirror_cap = 64;

    t_heap_result due_results [$];
    int           err_cnt = 0;

    binary_min_heap_queue_core #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // apply one word to the mirror heap and return the result it should give
    function automatic t_heap_result heap_apply(input logic [OpW-1:0] op,
                                                input logic [KeyW-1:0] key);
        t_heap_result           r;
        int                     pos;
        int                     up;
        int                     left;
        int                     pick;
        int                     lim;
        logic signed [KeyW-1:0] tmp;
        r.key = '0;
        r.status = StOk;
        lim = (mirror_cap < DEPTH) ? mirror_cap : DEPTH;
        case (op)
            OpInsert: begin
                if (mirror_count >= lim) begin
                    r.status = StFull;
                end else begin
                    mirror_keys[mirror_count] = key;
                    pos = mirror_count;
                    mirror_count++;
                    // sift up while the parent is larger
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (!(mirror_keys[pos] < mirror_keys[up])) break;
                        tmp = mirror_keys[up];
                        mirror_keys[up] = mirror_keys[pos];
                        mirror_keys[pos] = tmp;
                        pos = up;
                    end
                end
            end
            OpExtract, OpPeek: begin
                if (mirror_count == 0) begin
                    r.status = StEmpty;
                end else begin
                    r.key = mirror_keys[0];
                    if (op == OpExtract) begin
                        mirror_keys[0] = mirror_keys[mirror_count-1];
                        mirror_count--;
                        // sift down toward the smaller child, left on a tie
                        pos = 0;
                        while (1) begin
                            left = 2 * pos + 1;
                            if (left >= mirror_count) break;
                            pick = left;
                            if (left + 1 < mirror_count &&
                                mirror_keys[left+1] < mirror_keys[left])
                                pick = left + 1;
                            if (mirror_keys[pos] < mirror_keys[pick]) break;
                            tmp = mirror_keys[pos];
                            mirror_keys[pos] = mirror_keys[pick];
                            mirror_keys[pick] = tmp;
                            pos = pick;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.count = EntryW'(mirror_count);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KeyW-1:0] rand_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom();
        if (r < 88) return KeyW'($signed($urandom_range(0, 16)) - 8);
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // one input word; the expectation is queued at the accepting edge
    task automatic send_word(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                             input logic use_typed, input t_heap_result typed,
                             input logic no_gap);
        t_heap_result pred;
        int           gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = heap_apply(op, key);
        due_results.push_back(use_typed ? typed : pred);
        gap = no_gap ? 0 : rand_gap();
        // the core is busy after an accept
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        if (gap > 1) begin
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // capacity write while idle, then read it back
    task automatic write_capacity(input logic [LimitW-1:0] cap);
        while (due_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CapAddr;
        pwdata  <= CfgDataW'(cap);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mirror_cap = cap;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== CfgDataW'(cap)) begin
            $display("%0t capacity readback: expected %0d, got %0d", $time, cap, prdata);
            err_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random stalls between runs of ready
    initial begin : result_sink
        int run;
        int gap;
        forever begin
            run = $urandom_range(1, 30);
            repeat (run) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
            gap = rand_gap();
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                $display("%0t unexpected result word: key %h status %0d count %0d", $time,
                         m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[38:32]);
                err_cnt++;
            end else begin
                want = due_results.pop_front();
                if (m_axis_tdata[31:0] !== want.key) begin
                    $display("%0t key_out: expected %h, got %h", $time, want.key,
                             m_axis_tdata[31:0]);
                    err_cnt++;
                end
                if (m_axis_tuser !== want.status) begin
                    $display("%0t status: expected %0d, got %0d", $time, want.status,
                             m_axis_tuser);
                    err_cnt++;
                end
                if (m_axis_tdata[38:32] !== want.count) begin
                    $display("%0t entry_count: expected %0d, got %0d", $time, want.count,
                             m_axis_tdata[38:32]);
                    err_cnt++;
                end
                if (m_axis_tdata[39] !== 1'b0) begin
                    $display("%0t tdata pad bit: expected 0, got %b", $time,
                             m_axis_tdata[39]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    // stimulus: directed table, then random phases over several capacities
    initial begin : stimulus
        int            phase_caps [8];
        int            cap;
        int            n_items;
        int            bias;
        int            r;
        logic          burst_nogap;
        logic [OpW-1:0] op;
        t_heap_result  none;
        phase_caps = '{64, 1, 127, 0, 3, -1, 64, 2};
        none = '0;
        burst_nogap = 1'b0;
        bias = 2;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].kind == ROW_CFG)
                write_capacity(dir_tab[i].cap);
            else
                send_word(dir_tab[i].op, dir_tab[i].key, dir_tab[i].exact,
                          dir_tab[i].res, 1'b0);
        end

        for (int p = 0; p < 8; p++) begin
            cap = (phase_caps[p] < 0) ? $urandom_range(1, 64) : phase_caps[p];
            write_capacity(LimitW'(cap));
            n_items = (cap == 0) ? 40 : 125;
            for (int k = 0; k < n_items; k++) begin
                // new fill/drain/balanced bias and idling mode every 32 words
                if (k % 32 == 0) begin
                    bias = $urandom_range(0, 2);
                    burst_nogap = ($urandom_range(0, 3) == 0);
                end
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = OpUnused;
                else if (r < 15)
                    op = OpPeek;
                else begin
                    r = $urandom_range(0, 99);
                    case (bias)
                        0: op = (r < 75) ? OpInsert : OpExtract;
                        1: op = (r < 40) ? OpInsert : OpExtract;
                        default: op = (r < 57) ? OpInsert : OpExtract;
                    endcase
                end
                send_word(op, rand_key(), 1'b0, none, burst_nogap);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
